// ===== design/two_level_waveform_peak_builder_defines.svh =====
// Assertion macros for the two-level waveform peak builder.
// Needs signals clk and rst_n in the scope of each use; no other dependencies.
`ifndef TWO_LEVEL_WAVEFORM_PEAK_BUILDER_DEFINES_SVH
`define TWO_LEVEL_WAVEFORM_PEAK_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset
`define WPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the next cycle
`define WPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WPB_ASSERT(lbl, prop, msg)
`define WPB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/wpb_pkg.sv =====
// Shared types and constants for the two-level waveform peak builder.
// No dependencies; imported by every module of the block.
package wpb_pkg;

    // Sample format and stream widths
    localparam int SAMPLE_BITS  = 24;
    localparam int S_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Register and counter widths
    localparam int CHAN_BITS     = 5;
    localparam int POS_BITS      = 4;
    localparam int FRAME_BITS    = 16;
    localparam int PER_BITS      = 11;
    localparam int FINE_CNT_BITS = 10;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = CHAN_BITS'(16);
    localparam logic [PER_BITS-1:0]  PER_MAX  = PER_BITS'(1024);

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FINE_STEP       = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FINE_PER_COARSE = CFG_INDEX_BITS'(2);

    localparam logic [CHAN_BITS-1:0]  RST_CHANNEL_COUNT   = CHAN_BITS'(2);
    localparam logic [FRAME_BITS-1:0] RST_FINE_STEP       = FRAME_BITS'(256);
    localparam logic [PER_BITS-1:0]   RST_FINE_PER_COARSE = PER_BITS'(16);

    // Peak level codes
    localparam logic LEVEL_FINE   = 1'b0;
    localparam logic LEVEL_COARSE = 1'b1;

    // Output queue
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [CHAN_BITS-1:0]  channel_count;
        logic [FRAME_BITS-1:0] fine_step;
        logic [PER_BITS-1:0]   fine_per_coarse;
    } cfg_t;

    typedef struct packed {
        logic                          level;
        logic signed [SAMPLE_BITS-1:0] pmin;
        logic signed [SAMPLE_BITS-1:0] pmax;
        logic                          last;
    } peak_t;

    // Results produced by one accepted sample, in output order
    typedef struct packed {
        logic [1:0] count;
        peak_t      first;
        peak_t      second;
    } push_t;

endpackage

// ===== design/wpb_regs.sv =====
// Configuration registers of the waveform peak builder.
// Depends on wpb_pkg.
module wpb_regs
    import wpb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg           = cfg_reg;

    // Decode write beat; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT:   cfg_next.channel_count   = cfg_data[CHAN_BITS-1:0];
                REG_FINE_STEP:       cfg_next.fine_step       = cfg_data[FRAME_BITS-1:0];
                REG_FINE_PER_COARSE: cfg_next.fine_per_coarse = cfg_data[PER_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count   <= RST_CHANNEL_COUNT;
            cfg_reg.fine_step       <= RST_FINE_STEP;
            cfg_reg.fine_per_coarse <= RST_FINE_PER_COARSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/wpb_core.sv =====
// Per-sample min/max tracking for fine and coarse groups.
// Depends on wpb_pkg and the assertion macros header.
`include "two_level_waveform_peak_builder_defines.svh"

module wpb_core
    import wpb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          eoc,
    input  cfg_t                          cfg,
    output push_t                         push
);

    // Group state
    logic [POS_BITS-1:0]           pos_reg,    pos_next;
    logic [FRAME_BITS-1:0]         frames_reg, frames_next;
    logic [FINE_CNT_BITS-1:0]      fines_reg,  fines_next;
    logic signed [SAMPLE_BITS-1:0] gmin_reg,   gmin_next;
    logic signed [SAMPLE_BITS-1:0] gmax_reg,   gmax_next;
    logic signed [SAMPLE_BITS-1:0] cmin_reg,   cmin_next;
    logic signed [SAMPLE_BITS-1:0] cmax_reg,   cmax_next;

    // Effective limits
    logic [CHAN_BITS-1:0]  chans;
    logic [FRAME_BITS-1:0] step_eff;
    logic [PER_BITS-1:0]   per_eff;

    logic [POS_BITS-1:0]           pos_w;
    logic [CHAN_BITS-1:0]          pos_inc;
    logic [POS_BITS-1:0]           pos_adv;
    logic                          measure;
    logic                          grp_first;
    logic signed [SAMPLE_BITS-1:0] lo, hi, fmin, fmax, cmin_f, cmax_f;
    logic [FRAME_BITS:0]           frames_inc, frames_a;
    logic [PER_BITS-1:0]           fines_inc;
    logic                          close_m, close_f, coarse_close, coarse_only;

    // Clamp configuration
    always_comb
    begin
        if (cfg.channel_count == '0)
            chans = CHAN_BITS'(1);
        else if (cfg.channel_count > CHAN_MAX)
            chans = CHAN_MAX;
        else
            chans = cfg.channel_count;

        step_eff = (cfg.fine_step == '0) ? FRAME_BITS'(1) : cfg.fine_step;

        if (cfg.fine_per_coarse == '0)
            per_eff = PER_BITS'(1);
        else if (cfg.fine_per_coarse > PER_MAX)
            per_eff = PER_MAX;
        else
            per_eff = cfg.fine_per_coarse;
    end

    // Channel position, wrapped against the current channel count
    assign pos_w   = ({1'b0, pos_reg} >= chans) ? '0 : pos_reg;
    assign measure = (pos_w == '0);
    assign pos_inc = {1'b0, pos_w} + CHAN_BITS'(1);
    assign pos_adv = (pos_inc >= chans) ? '0 : pos_inc[POS_BITS-1:0];

    // Fine group update
    assign grp_first  = (frames_reg == '0);
    assign lo         = (grp_first || sample < gmin_reg) ? sample : gmin_reg;
    assign hi         = (grp_first || sample > gmax_reg) ? sample : gmax_reg;
    assign fmin       = measure ? lo : gmin_reg;
    assign fmax       = measure ? hi : gmax_reg;
    assign frames_inc = {1'b0, frames_reg} + (FRAME_BITS+1)'(1);
    assign frames_a   = measure ? frames_inc : {1'b0, frames_reg};
    assign close_m    = measure && (frames_inc >= {1'b0, step_eff});
    assign close_f    = close_m || (eoc && frames_a != '0);

    // Fold closing fine group into the coarse group
    assign cmin_f       = (fines_reg == '0 || fmin < cmin_reg) ? fmin : cmin_reg;
    assign cmax_f       = (fines_reg == '0 || fmax > cmax_reg) ? fmax : cmax_reg;
    assign fines_inc    = {1'b0, fines_reg} + PER_BITS'(1);
    assign coarse_close = close_f && (fines_inc >= per_eff || eoc);
    assign coarse_only  = !close_f && eoc && (fines_reg != '0);

    // Results for this beat: fine first, then coarse
    always_comb
    begin
        push = '0;
        if (accept)
        begin
            if (close_f)
            begin
                push.count        = coarse_close ? 2'd2 : 2'd1;
                push.first.level  = LEVEL_FINE;
                push.first.pmin   = fmin;
                push.first.pmax   = fmax;
                push.first.last   = !coarse_close;
                push.second.level = LEVEL_COARSE;
                push.second.pmin  = cmin_f;
                push.second.pmax  = cmax_f;
                push.second.last  = 1'b1;
            end
            else if (coarse_only)
            begin
                push.count       = 2'd1;
                push.first.level = LEVEL_COARSE;
                push.first.pmin  = cmin_reg;
                push.first.pmax  = cmax_reg;
                push.first.last  = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        pos_next    = pos_reg;
        frames_next = frames_reg;
        fines_next  = fines_reg;
        gmin_next   = gmin_reg;
        gmax_next   = gmax_reg;
        cmin_next   = cmin_reg;
        cmax_next   = cmax_reg;
        if (accept)
        begin
            gmin_next = fmin;
            gmax_next = fmax;
            if (close_f)
            begin
                cmin_next = cmin_f;
                cmax_next = cmax_f;
            end
            if (eoc)
            begin
                pos_next    = '0;
                frames_next = '0;
                fines_next  = '0;
            end
            else
            begin
                pos_next = pos_adv;
                if (close_f)
                begin
                    frames_next = '0;
                    fines_next  = coarse_close ? '0 : fines_inc[FINE_CNT_BITS-1:0];
                end
                else
                begin
                    frames_next = frames_a[FRAME_BITS-1:0];
                end
            end
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            frames_reg <= '0;
            fines_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            frames_reg <= frames_next;
            fines_reg  <= fines_next;
        end
    end

    // Min/max accumulators; only read while their group count is nonzero
    always_ff @(posedge clk)
    begin
        gmin_reg <= gmin_next;
        gmax_reg <= gmax_next;
        cmin_reg <= cmin_next;
        cmax_reg <= cmax_next;
    end

    `WPB_ASSERT(a_pair_order, push.count != 2'd2 || (push.first.level == LEVEL_FINE && push.second.level == LEVEL_COARSE && !push.first.last), "two results must be fine then coarse")
    `WPB_ASSERT_NEXT(a_eoc_clears, accept && eoc, pos_reg == '0 && frames_reg == '0 && fines_reg == '0, "end of clip must clear all counters")
    `WPB_ASSERT_NEXT(a_coarse_restarts, push.count == 2'd2, fines_reg == '0 && frames_reg == '0, "coarse close must restart both groups")

endmodule

// ===== design/wpb_outq.sv =====
// Small result queue between the peak logic and the output stream.
// Takes up to two results a beat, hands out one. Depends on wpb_pkg and macros.
`include "two_level_waveform_peak_builder_defines.svh"

module wpb_outq
    import wpb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  space,
    output logic  valid,
    input  logic  ready,
    output peak_t head
);

    peak_t                  q_reg [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0] wr_reg, wr_next;
    logic [OQ_PTR_BITS-1:0] rd_reg, rd_next;
    logic [OQ_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [OQ_PTR_BITS-1:0] wr_second;
    logic                   pop;

    // Room for a full pair of results
    assign space     = (cnt_reg <= OQ_CNT_BITS'(OQ_DEPTH - 2));
    assign valid     = (cnt_reg != '0);
    assign head      = q_reg[rd_reg];
    assign pop       = valid && ready;
    assign wr_second = wr_reg + OQ_PTR_BITS'(1);

    // Pointer and fill count
    always_comb
    begin
        wr_next  = wr_reg + OQ_PTR_BITS'(push.count);
        rd_next  = rd_reg + OQ_PTR_BITS'(pop);
        cnt_next = cnt_reg + OQ_CNT_BITS'(push.count) - OQ_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            q_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            q_reg[wr_second] <= push.second;
    end

    `WPB_ASSERT(a_no_overflow, cnt_reg <= OQ_CNT_BITS'(OQ_DEPTH), "result queue overflow")
    `WPB_ASSERT(a_push_has_room, push.count == 2'd0 || space, "results pushed without room")

endmodule

// ===== design/two_level_waveform_peak_builder.sv =====
// Top level of the two-level waveform peak builder.
// Depends on wpb_pkg, wpb_regs, wpb_core and wpb_outq.
//
// Takes one interleaved audio sample per beat and measures the first channel of
// each frame. Every fine_step frames it emits a fine peak (min and max), and every
// fine_per_coarse fine peaks a coarse peak; end of clip flushes partial groups
// and clears all counts. A sample is taken in every cycle while the four-entry
// result queue has room for two results; a sample's results enter the queue as
// it is accepted and leave it fine before coarse, and the last result a sample
// causes is marked with m_tlast. A sustained rate below one sample per cycle only
// arises when the output side stalls or takes results slower than they are made.
module two_level_waveform_peak_builder
    import wpb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Sample stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_DATA_BITS-1:0]    s_tdata,   // sample_value
    input  logic                      s_tlast,   // end_of_clip
    // Peak stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_DATA_BITS-1:0]    m_tdata,   // peak_min, peak_max
    output logic                      m_tuser,   // peak_level
    output logic                      m_tlast,   // last_of_run
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t  cfg;
    push_t push;
    peak_t head;
    logic  accept;
    logic  space;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    wpb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wpb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (s_tdata[SAMPLE_BITS-1:0]),
        .eoc    (s_tlast),
        .cfg    (cfg),
        .push   (push)
    );

    wpb_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .valid (m_tvalid),
        .ready (m_tready),
        .head  (head)
    );

    // Output beat packing
    assign m_tdata = M_DATA_BITS'({head.pmax, head.pmin});
    assign m_tuser = head.level;
    assign m_tlast = head.last;

endmodule
